// ----- design/matrix_multiply_engine_core_macros.svh -----
// ----------------------------------------------------------------------------
// matrix_multiply_engine_core_macros.svh
// Assertion shorthands for the matrix multiply engine.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mme_pkg.sv -----
// ----------------------------------------------------------------------------
// mme_pkg
// Types and codes shared by the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

  // Input item operation
  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mme_mode_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROWS_M  = 2'd0,
    CFG_INNER_K = 2'd1,
    CFG_COLS_N  = 2'd2
  } mme_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_EMIT
  } mme_state_e;

  localparam int unsigned DIM_W   = 4;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned ACC_W   = 40;
  localparam int unsigned DEPTH   = 64;

  typedef struct packed {
    logic [1:0]               mode;
    logic [IDX_W-1:0]         elem_index;
    logic signed [ELEM_W-1:0] elem_value;
  } mme_in_t;

  typedef struct packed {
    logic [CNT_W-1:0]        out_row;
    logic [CNT_W-1:0]        out_col;
    logic signed [ACC_W-1:0] dot_value;
    logic                    last;
  } mme_out_t;

endpackage

// ----- design/matrix_multiply_engine_core.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_engine_core
// C = A * B on up to 8x8 Q8.8 matrices held in two local stores; one shared
// multiply-accumulate unit walks every dot product, results in Q24.16.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  cfg     | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//  in      | in        | in_valid_i / in_stall_o   | in_data_i  (mme_in_t)
//  out     | out       | out_valid_o / out_stall_i | out_data_o (mme_out_t)
//
//  Loads of A or B transfer back to back whenever no compute item is in
//  progress. A compute item has the single MAC unit take one k step per
//  cycle, then drain store read, multiply and accumulate, and hold each
//  result in the output register until it transfers.
//  in_stall_o is high from the compute transfer until the last result leaves.
//  Output stalls hold the sequencer in place. Reset clears control only; the
//  stores hold nothing defined until written.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_core #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [3:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mme_pkg::mme_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mme_pkg::mme_out_t  out_data_o
);
  import mme_pkg::*;

  // Configuration
  logic [DIM_W-1:0] rows_m_q, inner_k_q, cols_n_q;
  logic [DIM_W-1:0] m_dim, k_dim, n_dim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m_q  <= DIM_W'(8);
      inner_k_q <= DIM_W'(8);
      cols_n_q  <= DIM_W'(8);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS_M:  rows_m_q  <= cfg_data_i;
        CFG_INNER_K: inner_k_q <= cfg_data_i;
        CFG_COLS_N:  cols_n_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturate dimensions at use: zero acts as one, large values as MAX_DIM
  always_comb begin
    m_dim = rows_m_q;
    k_dim = inner_k_q;
    n_dim = cols_n_q;
    if (m_dim == '0) m_dim = DIM_W'(1);
    if (k_dim == '0) k_dim = DIM_W'(1);
    if (n_dim == '0) n_dim = DIM_W'(1);
    if (m_dim > DIM_W'(MAX_DIM)) m_dim = DIM_W'(MAX_DIM);
    if (k_dim > DIM_W'(MAX_DIM)) k_dim = DIM_W'(MAX_DIM);
    if (n_dim > DIM_W'(MAX_DIM)) n_dim = DIM_W'(MAX_DIM);
  end

  logic [CNT_W-1:0] m_last, k_last, n_last;
  assign m_last = CNT_W'(m_dim - DIM_W'(1));
  assign k_last = CNT_W'(k_dim - DIM_W'(1));
  assign n_last = CNT_W'(n_dim - DIM_W'(1));

  // Sequencer
  mme_state_e       state_q, state_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d, p_q, p_d;
  logic [IDX_W-1:0] a_base_q, a_base_d, a_addr_q, a_addr_d, b_addr_q, b_addr_d;
  logic             out_valid_q, out_valid_d;
  logic             rd_vld_q, prod_vld_q;
  logic             in_xfer, out_xfer, issue, acc_clr, out_load, elem_last;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_xfer  = out_valid_q && !out_stall_i;
  assign elem_last = (i_q == m_last) && (j_q == n_last);

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    p_d         = p_q;
    a_base_d    = a_base_q;
    a_addr_d    = a_addr_q;
    b_addr_d    = b_addr_q;
    out_valid_d = out_valid_q;
    issue       = 1'b0;
    acc_clr     = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_data_i.mode == MODE_COMPUTE) begin
          state_d  = ST_READ;
          i_d      = '0;
          j_d      = '0;
          p_d      = '0;
          a_base_d = '0;
          a_addr_d = '0;
          b_addr_d = '0;
          acc_clr  = 1'b1;
        end
      end
      ST_READ: begin
        issue    = 1'b1;
        p_d      = p_q + CNT_W'(1);
        a_addr_d = a_addr_q + IDX_W'(1);
        b_addr_d = b_addr_q + IDX_W'(n_dim);
        if (p_q == k_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !prod_vld_q) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          out_valid_d = 1'b0;
          if (out_data_o.last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_READ;
            p_d     = '0;
            acc_clr = 1'b1;
            if (j_q == n_last) begin
              j_d      = '0;
              i_d      = i_q + CNT_W'(1);
              a_base_d = a_base_q + IDX_W'(k_dim);
            end else begin
              j_d = j_q + CNT_W'(1);
            end
            a_addr_d = a_base_d;
            b_addr_d = IDX_W'(j_d);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= issue;
      prod_vld_q  <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    j_q      <= j_d;
    p_q      <= p_d;
    a_base_q <= a_base_d;
    a_addr_q <= a_addr_d;
    b_addr_q <= b_addr_d;
  end

  // Element stores, one write and one registered read port each
  logic signed [ELEM_W-1:0] a_mem [DEPTH];
  logic signed [ELEM_W-1:0] b_mem [DEPTH];
  logic signed [ELEM_W-1:0] a_rd_q, b_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer && in_data_i.mode == MODE_LOAD_A) begin
      a_mem[in_data_i.elem_index] <= in_data_i.elem_value;
    end
    a_rd_q <= a_mem[a_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && in_data_i.mode == MODE_LOAD_B) begin
      b_mem[in_data_i.elem_index] <= in_data_i.elem_value;
    end
    b_rd_q <= b_mem[b_addr_q];
  end

  // Shared MAC: multiply stage, then accumulate
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  mme_out_t                 out_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_rd_q * b_rd_q;
    if (acc_clr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (out_load) begin
      out_q.out_row   <= i_q;
      out_q.out_col   <= j_q;
      out_q.dot_value <= acc_q;
      out_q.last      <= elem_last;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "matrix_multiply_engine_core_macros.svh"

  `MME_ASSERT_NOW(a_idle_no_result, !in_stall_o, !out_valid_o, "result pending while idle")
  `MME_ASSERT_NOW(a_idle_pipe_empty, state_q == ST_IDLE, !rd_vld_q && !prod_vld_q, "MAC busy")
  `MME_ASSERT_NOW(a_read_no_result, state_q == ST_READ, !out_valid_q, "result held during reads")
  `MME_ASSERT_NXT(a_last_to_idle, out_xfer && out_data_o.last, !in_stall_o, "not idle after last")

endmodule

// ----- tb/sv/matrix_multiply_engine_core_test.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_engine_core_test
// Self-checking bench for the matrix multiply engine. A scoreboard keeps its
// own copy of the A and B stores and the dimension registers, predicts every
// element of C on each compute transfer, and compares each output transfer
// field by field. Stimulus is a short directed set, then random load/compute
// sequences under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mme_pkg::*;

  localparam int          MAX_DIM      = 8;
  localparam int          ITEM_GOAL    = 165;  // the last batch runs past this
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [1:0]  MODE_IGNORED = 2'd3;
  localparam logic [1:0]  CFG_SPARE    = 2'd3;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [3:0] cfg_data_i = '0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  mme_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  mme_out_t out_data_o;

  matrix_multiply_engine_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // scoreboard state
  logic signed [15:0] a_shadow [64];
  logic signed [15:0] b_shadow [64];
  logic [3:0]         rows_reg  = 4'd8;
  logic [3:0]         inner_reg = 4'd8;
  logic [3:0]         cols_reg  = 4'd8;
  mme_out_t           elem_q [$];
  mme_in_t            feed_q [$];
  int                 mismatches = 0;
  int                 send_gap_pct = 0;
  int                 recv_stall_pct = 0;

  // generator bookkeeping: which entries have been loaded so far
  bit                 a_loaded [64];
  bit                 b_loaded [64];
  int                 n_items = 0;

  function automatic int eff_dim(logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic void run_matmul();
    int m, k, n;
    logic signed [39:0] acc;
    mme_out_t e;
    m = eff_dim(rows_reg);
    k = eff_dim(inner_reg);
    n = eff_dim(cols_reg);
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = '0;
        for (int p = 0; p < k; p++) begin
          acc = acc + a_shadow[(i * k + p) % 64] * b_shadow[(p * n + j) % 64];
        end
        e.out_row   = 3'(i);
        e.out_col   = 3'(j);
        e.dot_value = acc;
        e.last      = (i == m - 1) && (j == n - 1);
        elem_q.insert(elem_q.size(), e);
      end
    end
  endfunction

  function automatic void accept_item(mme_in_t it);
    case (it.mode)
      MODE_LOAD_A:  a_shadow[it.elem_index] = it.elem_value;
      MODE_LOAD_B:  b_shadow[it.elem_index] = it.elem_value;
      MODE_COMPUTE: run_matmul();
      default: ;  // ignored mode
    endcase
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_elem(mme_out_t got);
    mme_out_t want;
    if (elem_q.size() == 0) begin
      flag_mismatch("unexpected transfer, row", got.out_row, -1);
      return;
    end
    want = elem_q.pop_front();
    if (got.out_row !== want.out_row) flag_mismatch("out_row", got.out_row, want.out_row);
    if (got.out_col !== want.out_col) flag_mismatch("out_col", got.out_col, want.out_col);
    if (got.dot_value !== want.dot_value) begin
      flag_mismatch("dot_value", longint'(got.dot_value), longint'(want.dot_value));
    end
    if (got.last !== want.last) flag_mismatch("last", got.last, want.last);
  endtask

  // input side: hold the payload until the transfer, then maybe idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) accept_item(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (feed_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= feed_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_elem(out_data_o);
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void push_load(mme_mode_e mode, int idx, logic [15:0] val);
    mme_in_t it;
    it.mode       = mode;
    it.elem_index = 6'(idx);
    it.elem_value = val;
    if (mode == MODE_LOAD_A) a_loaded[idx] = 1'b1;
    else b_loaded[idx] = 1'b1;
    feed_q.insert(feed_q.size(), it);
    n_items++;
  endfunction

  function automatic void push_compute();
    mme_in_t it;
    it.mode       = MODE_COMPUTE;
    it.elem_index = 6'($urandom);
    it.elem_value = 16'($urandom);
    feed_q.insert(feed_q.size(), it);
    n_items++;
  endfunction

  function automatic void push_ignored();
    mme_in_t it;
    it.mode       = MODE_IGNORED;
    it.elem_index = 6'($urandom);
    it.elem_value = 16'($urandom);
    feed_q.insert(feed_q.size(), it);
    n_items++;
  endfunction

  function automatic void maybe_noise();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      push_ignored();
    end else if (r < 16) begin
      push_load($urandom_range(1) ? MODE_LOAD_B : MODE_LOAD_A,
                $urandom_range(63), pick_value());
    end
  endfunction

  // loads every operand entry the current dimensions read that is still
  // unwritten, and refreshes a random share of the rest
  function automatic void load_operands(int refresh_pct);
    int m, k, n, x;
    m = eff_dim(rows_reg);
    k = eff_dim(inner_reg);
    n = eff_dim(cols_reg);
    for (int i = 0; i < m; i++) begin
      for (int p = 0; p < k; p++) begin
        x = i * k + p;
        if (!a_loaded[x] || $urandom_range(99) < refresh_pct) begin
          push_load(MODE_LOAD_A, x, pick_value());
        end
        maybe_noise();
      end
    end
    for (int p = 0; p < k; p++) begin
      for (int j = 0; j < n; j++) begin
        x = p * n + j;
        if (!b_loaded[x] || $urandom_range(99) < refresh_pct) begin
          push_load(MODE_LOAD_B, x, pick_value());
        end
        maybe_noise();
      end
    end
  endfunction

  task automatic write_dims(logic [3:0] m, logic [3:0] k, logic [3:0] n, bit poke_spare);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ROWS_M;
    cfg_data_i <= m;
    rows_reg = m;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_INNER_K;
    cfg_data_i <= k;
    inner_reg = k;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COLS_N;
    cfg_data_i <= n;
    cols_reg = n;
    if (poke_spare) begin
      // unmapped index, must leave the dimensions alone
      @(posedge clk_i);
      cfg_idx_i  <= CFG_SPARE;
      cfg_data_i <= 4'($urandom);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // sender holds off until every expected element has arrived
  task automatic wait_idle();
    do @(negedge clk_i);
    while (feed_q.size() != 0 || in_valid_i || elem_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic void set_idle(int phase);
    case (phase)
      0: begin send_gap_pct = 16; recv_stall_pct = 74; end
      1: begin send_gap_pct = 74; recv_stall_pct = 16; end
      default: begin send_gap_pct = 0; recv_stall_pct = 0; end
    endcase
  endfunction

  function automatic logic [3:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 4'($urandom_range(1, 3));
    if (r < 80) return 4'd0;
    if (r < 90) return 4'($urandom_range(4, 8));
    return 4'($urandom_range(9, 15));
  endfunction

  initial begin
    set_idle(0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: 1x1x1 with extreme operands, ignored mode, index 63
    write_dims(4'd1, 4'd1, 4'd1, 1'b0);
    push_load(MODE_LOAD_A, 0, 16'h8000);
    push_load(MODE_LOAD_B, 0, 16'h8000);
    push_compute();
    push_load(MODE_LOAD_A, 0, 16'h7fff);
    push_compute();
    push_ignored();
    push_compute();
    push_load(MODE_LOAD_A, 63, 16'h7fff);
    push_load(MODE_LOAD_B, 63, 16'h8000);
    push_load(MODE_LOAD_B, 0, 16'h7fff);
    push_compute();
    wait_idle();

    // zero dimensions are used as one; spare index write is dropped
    write_dims(4'd0, 4'd0, 4'd0, 1'b1);
    push_compute();
    wait_idle();

    // tall and wide with the largest row and column counts
    write_dims(4'd8, 4'd1, 4'd15, 1'b0);
    load_operands(0);
    push_compute();
    wait_idle();

    // longest dot product
    write_dims(4'd1, 4'd15, 4'd1, 1'b0);
    push_compute();
    wait_idle();

    while (n_items < ITEM_GOAL) begin
      set_idle(n_items < 70 ? 0 : (n_items < 120 ? 1 : 2));
      write_dims(pick_dim(), pick_dim(), pick_dim(), $urandom_range(9) == 0);
      repeat ($urandom_range(1, 3)) begin
        load_operands(60);
        if ($urandom_range(3) == 0) maybe_noise();
        push_compute();
      end
      wait_idle();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/mme_pkg.sv
design/matrix_multiply_engine_core.sv
tb/sv/matrix_multiply_engine_core_test.sv
